@@ sv/accumulator_instruction_executor_assert.svh @@
// assertion macros for the accumulator instruction executor
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ACCUMULATOR_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define ACCUMULATOR_INSTRUCTION_EXECUTOR_ASSERT_SVH

// same-cycle implication
`define AIE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AIE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/aie_pkg.sv @@
// shared constants and types of the accumulator instruction executor
// no dependencies
`timescale 1ns / 1ps

package aie_pkg;

  localparam int MemWords = 100;
  localparam int WordW    = 32;
  localparam int AdrW     = 7;
  localparam int OpW      = 7;
  localparam int CntW     = 16;
  localparam int MemAw    = $clog2(MemWords);
  localparam int IterW    = $clog2(WordW);

  localparam logic [OpW-1:0] OpRead    = OpW'(10);
  localparam logic [OpW-1:0] OpWrite   = OpW'(11);
  localparam logic [OpW-1:0] OpLoad    = OpW'(20);
  localparam logic [OpW-1:0] OpStore   = OpW'(21);
  localparam logic [OpW-1:0] OpAdd     = OpW'(30);
  localparam logic [OpW-1:0] OpSub     = OpW'(31);
  localparam logic [OpW-1:0] OpDiv     = OpW'(32);
  localparam logic [OpW-1:0] OpMul     = OpW'(33);
  localparam logic [OpW-1:0] OpBr      = OpW'(40);
  localparam logic [OpW-1:0] OpBrNeg   = OpW'(41);
  localparam logic [OpW-1:0] OpBrZero  = OpW'(42);
  localparam logic [OpW-1:0] OpHalt    = OpW'(43);

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StHaltNow = 3'd1,
    StHalted  = 3'd2,
    StUnknown = 3'd3,
    StDivZero = 3'd4,
    StOvf     = 3'd5
  } status_e;

endpackage

@@ sv/accumulator_instruction_executor.sv @@
// accumulator machine instruction executor: top level with sequencer and shared adder
// depends on aie_pkg, aie_ram and accumulator_instruction_executor_assert.svh
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------------
//   in      | in_valid_i / in_ready_o | opcode_i, address_i, read_value_i
//   out     | out_valid_o/out_ready_i | write_valid_o, write_value_o, status_o,
//           |                         | acc_value_o, instr_count_o
//
// plain instructions pass through the execute and finish states before the next free input slot
// divide and multiply make 32 passes through the one 34-bit add/subtract unit,
// plus operand, magnitude, sign fixup, result and issue steps
// reset clears accumulator, counter, halted flag and the per-word valid bits of
// data memory; a word never written reads as zero
// a result waiting in the output register does not block the next transfer in
`timescale 1ns / 1ps
`include "accumulator_instruction_executor_assert.svh"

module accumulator_instruction_executor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [aie_pkg::OpW-1:0]    opcode_i,
  input  logic [aie_pkg::AdrW-1:0]   address_i,
  input  logic signed [aie_pkg::WordW-1:0] read_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       write_valid_o,
  output logic signed [aie_pkg::WordW-1:0] write_value_o,
  output logic [2:0]                 status_o,
  output logic signed [aie_pkg::WordW-1:0] acc_value_o,
  output logic [aie_pkg::CntW-1:0]   instr_count_o
);

  import aie_pkg::*;

  typedef enum logic [5:0] {
    SIdle = 6'b000001,
    SExec = 6'b000010,
    SPrep = 6'b000100,
    SIter = 6'b001000,
    SPost = 6'b010000,
    SFin  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic                 halted_q, halted_d;
  logic [WordW-1:0]     acc_q, acc_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [MemWords-1:0]  vld_q, vld_d;
  logic                 out_valid_q, out_valid_d;

  logic [OpW-1:0]       op_q, op_d;
  logic [AdrW-1:0]      adr_q, adr_d;
  logic [WordW-1:0]     rv_q, rv_d;
  logic [WordW-1:0]     hi_q, hi_d;
  logic [WordW-1:0]     lo_q, lo_d;
  logic [WordW-1:0]     dvs_q, dvs_d;
  logic                 neg_q, neg_d;
  logic [IterW-1:0]     itr_q, itr_d;
  status_e              st_q, st_d;
  logic                 wvld_q, wvld_d;
  logic [WordW-1:0]     wv_q, wv_d;

  logic                 o_wvld_q, o_wvld_d;
  logic [WordW-1:0]     o_wv_q, o_wv_d;
  status_e              o_st_q, o_st_d;
  logic [WordW-1:0]     o_acc_q, o_acc_d;
  logic [CntW-1:0]      o_cnt_q, o_cnt_d;

  // memory port
  logic                 ram_we;
  logic [WordW-1:0]     ram_wdata;
  logic [MemAw-1:0]     ram_raddr;
  logic [WordW-1:0]     ram_rdata;
  logic                 in_range_in, in_range_q;
  logic [WordW-1:0]     mword;

  // shared add/subtract unit
  logic [WordW:0]       add_a, add_b;
  logic                 add_sub;
  logic [WordW+1:0]     add_sum;

  logic                 ovf_addsub, neg_eff, big_mag, ovf_post;

  assign in_range_in = address_i < AdrW'(MemWords);
  assign in_range_q  = adr_q < AdrW'(MemWords);
  assign ram_raddr   = in_range_in ? address_i[MemAw-1:0] : '0;

  aie_ram #(
    .Width (WordW),
    .Depth (MemWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (adr_q[MemAw-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // words never written read as zero
  assign mword = (in_range_q && vld_q[adr_q[MemAw-1:0]]) ? ram_rdata : '0;

  assign add_sum = {1'b0, add_a} + (add_sub ? ~{1'b0, add_b} : {1'b0, add_b})
                 + {{(WordW+1){1'b0}}, add_sub};

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      SExec: begin
        if (op_q == OpAdd || op_q == OpSub) begin
          add_a   = {1'b0, acc_q};
          add_b   = {1'b0, mword};
          add_sub = (op_q == OpSub);
        end else begin
          add_b   = {1'b0, mword};
          add_sub = 1'b1;
        end
      end
      SPrep, SPost: begin
        add_b   = {1'b0, lo_q};
        add_sub = 1'b1;
      end
      SIter: begin
        if (op_q == OpDiv) begin
          // restoring division step, top bit of the difference set means a borrow
          add_a   = {hi_q, lo_q[WordW-1]};
          add_b   = {1'b0, dvs_q};
          add_sub = 1'b1;
        end else begin
          // shift-add multiply step
          add_a = {1'b0, hi_q};
          add_b = lo_q[0] ? {1'b0, dvs_q} : '0;
        end
      end
      SIdle, SFin: begin
        add_a = '0;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign ovf_addsub = (op_q == OpSub)
    ? (acc_q[WordW-1] != mword[WordW-1]) && (add_sum[WordW-1] != acc_q[WordW-1])
    : (acc_q[WordW-1] == mword[WordW-1]) && (add_sum[WordW-1] != acc_q[WordW-1]);

  assign neg_eff  = neg_q && (lo_q != '0);
  assign big_mag  = lo_q[WordW-1] && (!neg_eff || (lo_q[WordW-2:0] != '0));
  assign ovf_post = big_mag || ((op_q == OpMul) && (hi_q != '0));

  always_comb begin
    state_d     = state_q;
    halted_d    = halted_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    adr_d       = adr_q;
    rv_d        = rv_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    dvs_d       = dvs_q;
    neg_d       = neg_q;
    itr_d       = itr_q;
    st_d        = st_q;
    wvld_d      = wvld_q;
    wv_d        = wv_q;
    o_wvld_d    = o_wvld_q;
    o_wv_d      = o_wv_q;
    o_st_d      = o_st_q;
    o_acc_d     = o_acc_q;
    o_cnt_d     = o_cnt_q;
    ram_we      = 1'b0;
    ram_wdata   = rv_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          adr_d   = address_i;
          rv_d    = read_value_i;
          state_d = SExec;
        end
      end
      SExec: begin
        wvld_d  = 1'b0;
        wv_d    = '0;
        st_d    = StOk;
        state_d = SFin;
        if (halted_q) begin
          st_d = StHalted;
        end else begin
          unique case (op_q)
            OpRead: begin
              if (in_range_q) begin
                ram_we                    = 1'b1;
                ram_wdata                 = rv_q;
                vld_d[adr_q[MemAw-1:0]] = 1'b1;
              end
            end
            OpWrite: begin
              wvld_d = 1'b1;
              wv_d   = mword;
            end
            OpLoad: begin
              acc_d = mword;
            end
            OpStore: begin
              if (in_range_q) begin
                ram_we                    = 1'b1;
                ram_wdata                 = acc_q;
                vld_d[adr_q[MemAw-1:0]] = 1'b1;
              end
            end
            OpAdd, OpSub: begin
              if (ovf_addsub) begin
                st_d = StOvf;
              end else begin
                acc_d = add_sum[WordW-1:0];
              end
            end
            OpDiv, OpMul: begin
              if (op_q == OpDiv && mword == '0) begin
                st_d = StDivZero;
              end else begin
                lo_d    = acc_q;
                hi_d    = '0;
                dvs_d   = mword[WordW-1] ? add_sum[WordW-1:0] : mword;
                neg_d   = acc_q[WordW-1] ^ mword[WordW-1];
                itr_d   = '0;
                state_d = SPrep;
              end
            end
            OpBr, OpBrNeg, OpBrZero: begin
              st_d = StOk;
            end
            OpHalt: begin
              halted_d = 1'b1;
              st_d     = StHaltNow;
            end
            default: begin
              st_d = StUnknown;
            end
          endcase
          if (state_d == SFin && st_d == StOk) begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      SPrep: begin
        if (acc_q[WordW-1]) begin
          lo_d = add_sum[WordW-1:0];
        end
        state_d = SIter;
      end
      SIter: begin
        if (op_q == OpDiv) begin
          hi_d = add_sum[WordW+1] ? {hi_q[WordW-2:0], lo_q[WordW-1]} : add_sum[WordW-1:0];
          lo_d = {lo_q[WordW-2:0], !add_sum[WordW+1]};
        end else begin
          hi_d = add_sum[WordW:1];
          lo_d = {add_sum[0], lo_q[WordW-1:1]};
        end
        itr_d = itr_q + IterW'(1);
        if (itr_q == IterW'(WordW - 1)) begin
          state_d = SPost;
        end
      end
      SPost: begin
        if (ovf_post) begin
          st_d = StOvf;
        end else begin
          acc_d = neg_eff ? add_sum[WordW-1:0] : lo_q;
          cnt_d = cnt_q + CntW'(1);
          st_d  = StOk;
        end
        state_d = SFin;
      end
      SFin: begin
        if (!out_valid_q || out_ready_i) begin
          o_wvld_d    = wvld_q;
          o_wv_d      = wv_q;
          o_st_d      = st_q;
          o_acc_d     = acc_q;
          o_cnt_d     = cnt_q;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      halted_q    <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      halted_q    <= halted_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    adr_q    <= adr_d;
    rv_q     <= rv_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    dvs_q    <= dvs_d;
    neg_q    <= neg_d;
    itr_q    <= itr_d;
    st_q     <= st_d;
    wvld_q   <= wvld_d;
    wv_q     <= wv_d;
    o_wvld_q <= o_wvld_d;
    o_wv_q   <= o_wv_d;
    o_st_q   <= o_st_d;
    o_acc_q  <= o_acc_d;
    o_cnt_q  <= o_cnt_d;
  end

  assign in_ready_o    = (state_q == SIdle);
  assign out_valid_o   = out_valid_q;
  assign write_valid_o = o_wvld_q;
  assign write_value_o = o_wv_q;
  assign status_o      = o_st_q;
  assign acc_value_o   = o_acc_q;
  assign instr_count_o = o_cnt_q;

  `AIE_ASSERT_NXT(a_accept_to_exec, in_valid_i && in_ready_o, state_q == SExec,
                  "transfer in did not start execution")
  `AIE_ASSERT_NXT(a_halt_sticks, halted_q, halted_q, "halted flag cleared without reset")
  `AIE_ASSERT_IMP(a_wv_zero, out_valid_o && !write_valid_o, write_value_o == '0,
                  "write value not zero without a write")
  `AIE_ASSERT_NXT(a_iter_len, state_q == SPrep, itr_q == '0 && state_q == SIter,
                  "iteration did not start from zero")

endmodule

@@ sv/aie_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module aie_ram #(
  parameter int Width = 32,
  parameter int Depth = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ dv/accumulator_instruction_executor_tb.sv @@
// self-checking testbench for the accumulator instruction executor
// predicts each result from its own copy of memory, accumulator and counter
// depends on aie_pkg and accumulator_instruction_executor
`timescale 1ns / 1ps

module accumulator_instruction_executor_tb;
  import aie_pkg::*;

  localparam int  HoldCycles   = 150;
  localparam int  StallLimit   = 1000;
  localparam int  DrainCycles  = 60;
  localparam longint WordMax   = 64'sd2147483647;
  localparam longint WordMin   = -64'sd2147483648;

  typedef struct packed {
    logic             wr_valid;
    logic [WordW-1:0] wr_value;
    status_e          status;
    logic [WordW-1:0] acc;
    logic [CntW-1:0]  count;
  } outcome_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [OpW-1:0]          opcode_i = '0;
  logic [AdrW-1:0]         address_i = '0;
  logic signed [WordW-1:0] read_value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    write_valid_o;
  logic signed [WordW-1:0] write_value_o;
  logic [2:0]              status_o;
  logic signed [WordW-1:0] acc_value_o;
  logic [CntW-1:0]         instr_count_o;

  // machine state as the block should hold it
  logic signed [WordW-1:0] data_words [MemWords];
  logic signed [WordW-1:0] acc_q;
  logic [CntW-1:0]         count_q;
  logic                    halted_q;

  outcome_t predicted_outcomes [$];
  outcome_t want;
  int       n_errors = 0;
  int       idle_cycles = 0;
  logic     idle_off = 1'b0;
  int       hold_reqs = 0;

  accumulator_instruction_executor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .address_i     (address_i),
    .read_value_i  (read_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .write_valid_o (write_valid_o),
    .write_value_o (write_value_o),
    .status_o      (status_o),
    .acc_value_o   (acc_value_o),
    .instr_count_o (instr_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic outcome_t execute_instr(logic [OpW-1:0] op, logic [AdrW-1:0] adr,
                                             logic signed [WordW-1:0] rv);
    outcome_t                o;
    logic signed [WordW-1:0] m;
    logic                    in_range;
    longint                  wide;
    o = '0;
    o.status = StOk;
    in_range = adr < MemWords;
    m = in_range ? data_words[adr] : '0;
    if (halted_q) begin
      o.status = StHalted;
    end else begin
      case (op)
        OpRead: begin
          if (in_range) data_words[adr] = rv;
        end
        OpWrite: begin
          o.wr_valid = 1'b1;
          o.wr_value = m;
        end
        OpLoad: acc_q = m;
        OpStore: begin
          if (in_range) data_words[adr] = acc_q;
        end
        OpAdd, OpSub, OpDiv, OpMul: begin
          if (op == OpDiv && m == 0) begin
            o.status = StDivZero;
          end else begin
            // exact result in 64 bits, then range check at word width
            case (op)
              OpAdd:   wide = longint'(acc_q) + longint'(m);
              OpSub:   wide = longint'(acc_q) - longint'(m);
              OpDiv:   wide = longint'(acc_q) / longint'(m);
              default: wide = longint'(acc_q) * longint'(m);
            endcase
            if (wide > WordMax || wide < WordMin) o.status = StOvf;
            else acc_q = wide[WordW-1:0];
          end
        end
        OpBr, OpBrNeg, OpBrZero: ;
        OpHalt: begin
          halted_q = 1'b1;
          o.status = StHaltNow;
        end
        default: o.status = StUnknown;
      endcase
      if (o.status == StOk) count_q = count_q + 1'b1;
    end
    o.acc = acc_q;
    o.count = count_q;
    return o;
  endfunction

  // result checks first, then prediction of the instruction taken at this edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < MemWords; i++) data_words[i] = '0;
      acc_q    = '0;
      count_q  = '0;
      halted_q = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_outcomes.size() == 0) begin
          $error("result transfer with no instruction outstanding");
          n_errors++;
        end else begin
          want = predicted_outcomes.pop_front();
          if (write_valid_o !== want.wr_valid) begin
            $error("write_valid: expected %0d, got %0d", want.wr_valid, write_valid_o);
            n_errors++;
          end
          if (write_value_o !== want.wr_value) begin
            $error("write_value: expected %h, got %h", want.wr_value, write_value_o);
            n_errors++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            n_errors++;
          end
          if (acc_value_o !== want.acc) begin
            $error("acc_value: expected %h, got %h", want.acc, acc_value_o);
            n_errors++;
          end
          if (instr_count_o !== want.count) begin
            $error("instr_count: expected %0d, got %0d", want.count, instr_count_o);
            n_errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o)
        predicted_outcomes.push_back(execute_instr(opcode_i, address_i, read_value_i));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("accumulator_instruction_executor_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall per result, one long hold per request
  initial begin
    int unsigned stall;
    int          holds_done;
    holds_done = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_reqs != holds_done) begin
        stall = HoldCycles;
        holds_done = holds_done + 1;
      end else begin
        stall = idle_off ? 0 : $urandom_range(0, 7);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // leaves valid high on return so a following item can go out with no gap
  task automatic send_instr(logic [OpW-1:0] op, logic [AdrW-1:0] adr, logic [WordW-1:0] rv);
    int unsigned gap;
    gap = idle_off ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    address_i    <= adr;
    read_value_i <= rv;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random_instr();
    logic [OpW-1:0]   op;
    logic [AdrW-1:0]  adr;
    logic [WordW-1:0] rv;
    if ($urandom_range(0, 99) < 88) begin
      case ($urandom_range(0, 12))
        0, 1:    op = OpRead;
        2:       op = OpWrite;
        3, 4:    op = OpLoad;
        5:       op = OpStore;
        6:       op = OpAdd;
        7:       op = OpSub;
        8:       op = OpDiv;
        9, 10:   op = OpMul;
        11:      op = OpBr;
        default: op = ($urandom_range(0, 1) == 0) ? OpBrNeg : OpBrZero;
      endcase
    end else begin
      // anything but halt, which would leave the machine halted for the rest of the run
      do op = OpW'($urandom_range(0, (1 << OpW) - 1)); while (op == OpHalt);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: adr = AdrW'($urandom_range(0, 7));
      7, 8:                adr = AdrW'($urandom_range(0, MemWords - 1));
      default:             adr = AdrW'($urandom_range(MemWords, (1 << AdrW) - 1));
    endcase
    case ($urandom_range(0, 5))
      0: rv = $urandom_range(0, 40) - 20;
      1: begin
        case ($urandom_range(0, 4))
          0:       rv = 32'h7fff_ffff;
          1:       rv = 32'h8000_0000;
          2:       rv = '0;
          3:       rv = '1;
          default: rv = 32'd1;
        endcase
      end
      2, 3: rv = $urandom;
      4:    rv = $urandom_range(0, 1000);
      default: rv = -$urandom_range(0, 65535);
    endcase
    send_instr(op, adr, rv);
  endtask

  task automatic test_memory_words();
    send_instr(OpRead, AdrW'(0), 32'h7fff_ffff);
    send_instr(OpRead, AdrW'(MemWords - 1), 32'h8000_0000);
    send_instr(OpWrite, AdrW'(0), '0);
    send_instr(OpWrite, AdrW'(MemWords - 1), '0);
    // past the end: read is dropped, write returns zero
    send_instr(OpRead, '1, 32'h1234_5678);
    send_instr(OpWrite, '1, '0);
    send_instr(OpWrite, AdrW'(50), '0);
  endtask

  task automatic test_arith_edges();
    send_instr(OpRead, AdrW'(1), '1);
    send_instr(OpLoad, AdrW'(0), '0);
    send_instr(OpAdd, AdrW'(0), '0);
    send_instr(OpAdd, AdrW'(1), '0);
    send_instr(OpLoad, AdrW'(MemWords - 1), '0);
    send_instr(OpSub, AdrW'(0), '0);
    // most negative word by minus one overflows both ways
    send_instr(OpDiv, AdrW'(1), '0);
    send_instr(OpMul, AdrW'(1), '0);
    send_instr(OpDiv, AdrW'(50), '0);
    send_instr(OpDiv, AdrW'(0), '0);
    send_instr(OpMul, AdrW'(0), '0);
    send_instr(OpStore, AdrW'(2), '0);
    send_instr(OpWrite, AdrW'(2), '0);
    send_instr(OpLoad, '1, '0);
    send_instr(OpMul, AdrW'(0), '0);
  endtask

  task automatic test_branch_and_unknown();
    send_instr(OpBr, AdrW'(3), '0);
    send_instr(OpBrNeg, AdrW'(4), '0);
    send_instr(OpBrZero, '1, '0);
    send_instr('0, AdrW'(5), '0);
    send_instr('1, AdrW'(6), '0);
    send_instr(OpHalt + 1'b1, AdrW'(7), '0);
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) send_random_instr();
  endtask

  task automatic test_back_to_back(int n);
    idle_off = 1'b1;
    repeat (n) send_random_instr();
    idle_off = 1'b0;
  endtask

  task automatic test_output_backpressure();
    idle_off = 1'b1;
    hold_reqs = hold_reqs + 1;
    repeat (24) send_random_instr();
    idle_off = 1'b0;
  endtask

  task automatic test_halt();
    send_instr(OpHalt, AdrW'(9), '0);
    send_instr(OpRead, AdrW'(0), 32'h5555_aaaa);
    send_instr(OpWrite, AdrW'(0), '0);
    send_instr(OpAdd, AdrW'(0), '0);
    send_instr('1, '1, '1);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_memory_words();
    test_arith_edges();
    test_branch_and_unknown();
    test_random_traffic(200);
    test_back_to_back(80);
    test_output_backpressure();
    test_random_traffic(120);
    test_back_to_back(30);
    test_halt();
    in_valid_i <= 1'b0;

    while (predicted_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("accumulator_instruction_executor_tb: clean");
    end else begin
      $display("accumulator_instruction_executor_tb: errors");
    end
    $finish;
  end

endmodule
